// ===== rtl/ght_pkg.sv =====
package ght_pkg;

    // fixed field widths
    localparam int HANDLE_W = 32;
    localparam int USAGE_W  = 32;
    localparam int SIZE_W   = 40;
    localparam int KIND_W   = 2;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    // default geometry
    localparam int DEF_SLOT_COUNT = 1024;
    localparam int DEF_INDEX_BITS = 20;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UPLOAD  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADARG  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OOB     = 3'd4;

    // memory kinds
    localparam logic [KIND_W-1:0] KIND_GPU      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HOST     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READBACK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

    // transfer-destination usage bit
    localparam logic [USAGE_W-1:0] XFER_DST_BIT = 32'h0000_0002;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pop;
        logic exec;
    } t_ght_cmd;

    // datapath to controller
    typedef struct packed {
        logic pop_needed;
    } t_ght_stat;

endpackage

// ===== rtl/ght_ram.sv =====
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ght_ctrl.sv =====
module ght_ctrl
    import ght_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  logic      i_stall,
    input  t_ght_stat i_stat,
    output t_ght_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_ght_cmd   cmd;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        cmd.load = 1'b0;
        cmd.pop  = 1'b0;
        cmd.exec = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = i_stat.pop_needed ? S_POP : S_EXEC;
                end
            end
            S_POP: begin
                cmd.pop = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                // result register must be free or draining this cycle
                if (!r_out_valid || !i_stall) begin
                    cmd.exec = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

endmodule

// ===== rtl/ght_dpath.sv =====
module ght_dpath
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ght_cmd            i_cmd_ctl,
    output t_ght_stat           o_stat,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [SIZE_W-1:0]   i_buf_size,
    input  logic [USAGE_W-1:0]  i_usage_flags,
    input  logic [KIND_W-1:0]   i_memory_kind,
    input  logic [SIZE_W-1:0]   i_write_offset,
    input  logic [SIZE_W-1:0]   i_write_length,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic [USAGE_W-1:0]  o_usage_out,
    output logic [SIZE_W-1:0]   o_size_out,
    output logic [KIND_W-1:0]   o_kind_out,
    output logic                o_staged_path
);

    localparam int ADDR_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int GEN_W      = HANDLE_W - INDEX_BITS;
    localparam int SLOT_W     = GEN_W + 1 + KIND_W + SIZE_W;
    localparam int SLOT_LIMIT = (SLOT_COUNT < (1 << INDEX_BITS)) ? SLOT_COUNT
                                                                 : (1 << INDEX_BITS);
    localparam logic [HANDLE_W-1:0] IDX_MASK = HANDLE_W'((64'd1 << INDEX_BITS) - 64'd1);

    // latched item
    logic [CMD_W-1:0]    r_cmd;
    logic [HANDLE_W-1:0] r_handle;
    logic [SIZE_W-1:0]   r_size;
    logic [USAGE_W-1:0]  r_usage;
    logic [KIND_W-1:0]   r_kind;
    logic [SIZE_W-1:0]   r_off;
    logic [SIZE_W-1:0]   r_len;
    logic                r_from_stack;
    logic [ADDR_W-1:0]   r_idx;

    // allocator counters
    logic [CNT_W-1:0] r_free_count;
    logic [CNT_W-1:0] n_free_count;
    logic [CNT_W-1:0] r_fresh_next;
    logic [CNT_W-1:0] n_fresh_next;
    logic [CNT_W-1:0] free_m1;

    // result registers
    logic [STATUS_W-1:0] r_status;
    logic [HANDLE_W-1:0] r_handle_out;
    logic [USAGE_W-1:0]  r_usage_out;
    logic [SIZE_W-1:0]   r_size_out;
    logic [KIND_W-1:0]   r_kind_out;
    logic                r_staged;
    logic [STATUS_W-1:0] n_status;
    logic [HANDLE_W-1:0] n_handle_out;
    logic [USAGE_W-1:0]  n_usage_out;
    logic [SIZE_W-1:0]   n_size_out;
    logic [KIND_W-1:0]   n_kind_out;
    logic                n_staged;

    // memory ports
    logic [HANDLE_W-1:0] in_idx32;
    logic [ADDR_W-1:0]   in_addr;
    logic [ADDR_W-1:0]   slot_rd_addr;
    logic [SLOT_W-1:0]   slot_rd;
    logic                slot_wr_en;
    logic [SLOT_W-1:0]   slot_wr_data;
    logic [ADDR_W-1:0]   stack_rd;
    logic                stack_wr_en;

    // slot entry fields
    logic [GEN_W-1:0]  rd_gen;
    logic              rd_live;
    logic [KIND_W-1:0] rd_kind;
    logic [SIZE_W-1:0] rd_size;

    // execute terms
    logic [HANDLE_W-1:0] look_idx32;
    logic                found;
    logic [GEN_W-1:0]    old_gen;
    logic [GEN_W-1:0]    new_gen;
    logic                bad_create;
    logic                full;
    logic [SIZE_W:0]     win_end;

    assign rd_gen  = slot_rd[SLOT_W-1 -: GEN_W];
    assign rd_live = slot_rd[SIZE_W + KIND_W];
    assign rd_kind = slot_rd[SIZE_W +: KIND_W];
    assign rd_size = slot_rd[SIZE_W-1:0];

    // slot address of an incoming item
    assign in_idx32 = HANDLE_W'(i_handle[INDEX_BITS-1:0]);
    assign in_addr  = (i_cmd == CMD_CREATE) ? r_fresh_next[ADDR_W-1:0]
                                            : in_idx32[ADDR_W-1:0];
    assign slot_rd_addr = i_cmd_ctl.pop ? stack_rd : in_addr;
    assign free_m1      = r_free_count - CNT_W'(1);

    assign o_stat.pop_needed = (i_cmd == CMD_CREATE) && (r_free_count != '0);

    ght_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (slot_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (slot_wr_data),
        .i_rd_en   (i_cmd_ctl.load | i_cmd_ctl.pop),
        .i_rd_addr (slot_rd_addr),
        .o_rd_data (slot_rd)
    );

    ght_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (SLOT_COUNT)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stack_wr_en),
        .i_wr_addr (r_free_count[ADDR_W-1:0]),
        .i_wr_data (r_idx),
        .i_rd_en   (i_cmd_ctl.load),
        .i_rd_addr (free_m1[ADDR_W-1:0]),
        .o_rd_data (stack_rd)
    );

    // handle resolution and command checks
    always_comb begin
        look_idx32 = HANDLE_W'(r_handle[INDEX_BITS-1:0]);
        found      = (look_idx32 != '0) && (look_idx32 < HANDLE_W'(r_fresh_next))
                     && rd_live && (rd_gen == r_handle[HANDLE_W-1:INDEX_BITS]);
        // a fresh slot was never written, its generation is still zero
        old_gen    = r_from_stack ? rd_gen : '0;
        new_gen    = (old_gen == {GEN_W{1'b1}}) ? GEN_W'(1) : old_gen + GEN_W'(1);
        bad_create = (r_size == '0) || (r_usage == '0) || (r_kind == KIND_NONE);
        full       = !r_from_stack && (HANDLE_W'(r_fresh_next) >= HANDLE_W'(SLOT_LIMIT));
        win_end    = {1'b0, r_off} + {1'b0, r_len};
    end

    // result and state update
    always_comb begin
        n_status     = ST_OK;
        n_handle_out = '0;
        n_usage_out  = '0;
        n_size_out   = '0;
        n_kind_out   = '0;
        n_staged     = 1'b0;
        n_free_count = r_free_count;
        n_fresh_next = r_fresh_next;
        slot_wr_en   = 1'b0;
        slot_wr_data = slot_rd;
        stack_wr_en  = 1'b0;
        unique case (r_cmd)
            CMD_CREATE: begin
                if (bad_create) begin
                    n_status = ST_BADARG;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    if (r_from_stack) begin
                        n_free_count = free_m1;
                    end else begin
                        n_fresh_next = r_fresh_next + CNT_W'(1);
                    end
                    slot_wr_en   = 1'b1;
                    slot_wr_data = {new_gen, 1'b1, r_kind, r_size};
                    n_handle_out = (HANDLE_W'(new_gen) << INDEX_BITS)
                                   | (HANDLE_W'(r_idx) & IDX_MASK);
                    n_usage_out  = r_usage | ((r_kind == KIND_GPU) ? XFER_DST_BIT : '0);
                    n_kind_out   = r_kind;
                end
            end
            CMD_DESTROY: begin
                if (!found) begin
                    n_status = ST_INVALID;
                end else begin
                    slot_wr_en   = 1'b1;
                    slot_wr_data = {rd_gen, 1'b0, rd_kind, rd_size};
                    if (HANDLE_W'(r_free_count) < HANDLE_W'(SLOT_COUNT)) begin
                        stack_wr_en  = 1'b1;
                        n_free_count = r_free_count + CNT_W'(1);
                    end
                end
            end
            CMD_QUERY: begin
                if (!found) begin
                    n_status = ST_INVALID;
                end else begin
                    n_size_out = rd_size;
                    n_kind_out = rd_kind;
                end
            end
            CMD_UPLOAD: begin
                if (r_len == '0) begin
                    n_status = ST_BADARG;
                end else if (!found) begin
                    n_status = ST_INVALID;
                end else if (win_end > {1'b0, rd_size}) begin
                    n_status = ST_OOB;
                end else begin
                    n_kind_out = rd_kind;
                    n_staged   = (rd_kind == KIND_GPU);
                end
            end
        endcase
        if (!i_cmd_ctl.exec) begin
            slot_wr_en  = 1'b0;
            stack_wr_en = 1'b0;
        end
    end

    // item and slot index capture
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load) begin
            r_cmd        <= i_cmd;
            r_handle     <= i_handle;
            r_size       <= i_buf_size;
            r_usage      <= i_usage_flags;
            r_kind       <= i_memory_kind;
            r_off        <= i_write_offset;
            r_len        <= i_write_length;
            r_from_stack <= o_stat.pop_needed;
            r_idx        <= in_addr;
        end else if (i_cmd_ctl.pop) begin
            r_idx <= stack_rd;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.exec) begin
            r_status     <= n_status;
            r_handle_out <= n_handle_out;
            r_usage_out  <= n_usage_out;
            r_size_out   <= n_size_out;
            r_kind_out   <= n_kind_out;
            r_staged     <= n_staged;
        end
    end

    // allocator counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_count <= '0;
            r_fresh_next <= CNT_W'(1);
        end else if (i_cmd_ctl.exec) begin
            r_free_count <= n_free_count;
            r_fresh_next <= n_fresh_next;
        end
    end

    assign o_status      = r_status;
    assign o_handle_out  = r_handle_out;
    assign o_usage_out   = r_usage_out;
    assign o_size_out    = r_size_out;
    assign o_kind_out    = r_kind_out;
    assign o_staged_path = r_staged;

endmodule

// ===== rtl/generational_handle_table_unit.sv =====
// channel   valid     stall     payload
// request   i_valid   o_stall   i_cmd i_handle i_buf_size i_usage_flags i_memory_kind
//                               i_write_offset i_write_length
// result    o_valid   i_stall   o_status o_handle_out o_usage_out o_size_out o_kind_out
//                               o_staged_path
//
// one request at a time; a create that pops the free stack takes an extra pop state,
// set by the dependent reads of the free stack ram and the slot ram.
// a fresh slot is tracked by the fresh counter, so reset needs no clearing pass.
// a waiting result does not block the next request transfer; execution of that
// request holds until the result register drains.
module generational_handle_table_unit
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [SIZE_W-1:0]   i_buf_size,
    input  logic [USAGE_W-1:0]  i_usage_flags,
    input  logic [KIND_W-1:0]   i_memory_kind,
    input  logic [SIZE_W-1:0]   i_write_offset,
    input  logic [SIZE_W-1:0]   i_write_length,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic [USAGE_W-1:0]  o_usage_out,
    output logic [SIZE_W-1:0]   o_size_out,
    output logic [KIND_W-1:0]   o_kind_out,
    output logic                o_staged_path
);

    t_ght_cmd  cmd_ctl;
    t_ght_stat stat;

    ght_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd_ctl)
    );

    ght_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .INDEX_BITS (INDEX_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_ctl      (cmd_ctl),
        .o_stat         (stat),
        .i_cmd          (i_cmd),
        .i_handle       (i_handle),
        .i_buf_size     (i_buf_size),
        .i_usage_flags  (i_usage_flags),
        .i_memory_kind  (i_memory_kind),
        .i_write_offset (i_write_offset),
        .i_write_length (i_write_length),
        .o_status       (o_status),
        .o_handle_out   (o_handle_out),
        .o_usage_out    (o_usage_out),
        .o_size_out     (o_size_out),
        .o_kind_out     (o_kind_out),
        .o_staged_path  (o_staged_path)
    );

`ifndef SYNTHESIS
    // a request transfer always leaves the block busy next cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted while busy not raised");

    // a new handle never carries generation zero or the reserved slot
    a_handle_nonzero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK && o_handle_out != '0) |->
        (o_handle_out[HANDLE_W-1:INDEX_BITS] != '0 && o_handle_out[INDEX_BITS-1:0] != '0))
        else $error("handle with zero generation or slot");

    // staged path only for a good upload to gpu only memory
    a_staged_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_staged_path) |-> (o_status == ST_OK && o_kind_out == KIND_GPU))
        else $error("staged path with wrong status or kind");

    // failed commands return an empty payload
    a_error_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
        (o_handle_out == '0 && o_usage_out == '0 && o_size_out == '0
         && o_kind_out == '0 && !o_staged_path))
        else $error("error result with nonzero payload");
`endif

endmodule

// ===== tb/sv/handle_table_checker.sv =====
module handle_table_checker
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_stall,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [SIZE_W-1:0]   i_buf_size,
    input  logic [USAGE_W-1:0]  i_usage_flags,
    input  logic [KIND_W-1:0]   i_memory_kind,
    input  logic [SIZE_W-1:0]   i_write_offset,
    input  logic [SIZE_W-1:0]   i_write_length,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_stall,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [HANDLE_W-1:0] i_handle_out,
    input  logic [USAGE_W-1:0]  i_usage_out,
    input  logic [SIZE_W-1:0]   i_size_out,
    input  logic [KIND_W-1:0]   i_kind_out,
    input  logic                i_staged_path,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int GEN_W      = HANDLE_W - INDEX_BITS;
    localparam int GEN_MAX    = (1 << GEN_W) - 1;
    localparam int SLOT_LIMIT = (SLOT_COUNT < (1 << INDEX_BITS)) ? SLOT_COUNT
                                                                 : (1 << INDEX_BITS);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [USAGE_W-1:0]  usage;
        logic [SIZE_W-1:0]   bytes;
        logic [KIND_W-1:0]   kind;
        logic                staged;
    } t_reply;

    // shadow copy of the slot table
    logic [GEN_W-1:0]  slot_gen      [SLOT_COUNT];
    logic              slot_live     [SLOT_COUNT];
    logic [SIZE_W-1:0] slot_bytes    [SLOT_COUNT];
    logic [KIND_W-1:0] slot_mem_kind [SLOT_COUNT];
    int unsigned       free_slots    [SLOT_COUNT];
    int unsigned       free_depth;
    int unsigned       fresh_slot;

    t_reply expected_replies[$];
    int     mismatches;

    // slot index of a live handle whose generation matches, else 0
    function automatic int unsigned resolve_slot(input logic [HANDLE_W-1:0] h);
        int unsigned idx;
        int unsigned gen;
        idx = 32'(h[INDEX_BITS-1:0]);
        gen = h >> INDEX_BITS;
        if (idx == 0 || idx >= fresh_slot || idx >= SLOT_COUNT) return 0;
        if (!slot_live[idx] || slot_gen[idx] != gen) return 0;
        return idx;
    endfunction

    // applies one command to the shadow table and returns its reply
    function automatic t_reply predict_handle_op(
        input logic [CMD_W-1:0]    cmd,
        input logic [HANDLE_W-1:0] h,
        input logic [SIZE_W-1:0]   bytes,
        input logic [USAGE_W-1:0]  usage,
        input logic [KIND_W-1:0]   kind,
        input logic [SIZE_W-1:0]   offset,
        input logic [SIZE_W-1:0]   length
    );
        t_reply      r;
        int unsigned idx;
        int unsigned g;
        r        = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_CREATE: begin
                if (bytes == '0 || usage == '0 || kind == KIND_NONE) begin
                    r.status = ST_BADARG;
                end else if (free_depth == 0 && fresh_slot >= SLOT_LIMIT) begin
                    r.status = ST_FULL;
                end else begin
                    // reuse the most recently freed slot first
                    if (free_depth > 0) begin
                        free_depth--;
                        idx = free_slots[free_depth];
                    end else begin
                        idx = fresh_slot;
                        fresh_slot++;
                    end
                    g = slot_gen[idx] + 1;
                    if (g > GEN_MAX) g = 1;
                    slot_gen[idx]      = GEN_W'(g);
                    slot_live[idx]     = 1'b1;
                    slot_bytes[idx]    = bytes;
                    slot_mem_kind[idx] = kind;
                    r.handle = HANDLE_W'((g << INDEX_BITS) | idx);
                    r.usage  = usage | ((kind == KIND_GPU) ? XFER_DST_BIT : '0);
                    r.kind   = kind;
                end
            end
            CMD_DESTROY: begin
                idx = resolve_slot(h);
                if (idx == 0) begin
                    r.status = ST_INVALID;
                end else begin
                    slot_live[idx]  = 1'b0;
                    slot_bytes[idx] = '0;
                    if (free_depth < SLOT_COUNT) begin
                        free_slots[free_depth] = idx;
                        free_depth++;
                    end
                end
            end
            CMD_QUERY: begin
                idx = resolve_slot(h);
                if (idx == 0) begin
                    r.status = ST_INVALID;
                end else begin
                    r.bytes = slot_bytes[idx];
                    r.kind  = slot_mem_kind[idx];
                end
            end
            default: begin
                // upload: zero length is rejected before the handle is looked at
                if (length == '0) begin
                    r.status = ST_BADARG;
                end else begin
                    idx = resolve_slot(h);
                    if (idx == 0) begin
                        r.status = ST_INVALID;
                    end else if (({1'b0, offset} + {1'b0, length}) > {1'b0, slot_bytes[idx]}) begin
                        r.status = ST_OOB;
                    end else begin
                        r.kind   = slot_mem_kind[idx];
                        r.staged = (slot_mem_kind[idx] == KIND_GPU);
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // compare result transfers in order, then record request transfers
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                slot_gen[s]  = '0;
                slot_live[s] = 1'b0;
            end
            free_depth = 0;
            fresh_slot = 1;
            expected_replies.delete();
            mismatches   = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with nothing expected, status %0h",
                                 $time, i_status);
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("handle_out", want.handle, i_handle_out);
                    check_field("usage_out", want.usage, i_usage_out);
                    check_field("size_out", want.bytes, i_size_out);
                    check_field("kind_out", want.kind, i_kind_out);
                    check_field("staged_path", want.staged, i_staged_path);
                end
            end
            if (i_req_valid && !i_req_stall) begin
                want = predict_handle_op(i_cmd, i_handle, i_buf_size,
                    i_usage_flags, i_memory_kind, i_write_offset, i_write_length);
                expected_replies.insert(expected_replies.size(), want);
            end
            o_pending    <= expected_replies.size();
            o_fail_count <= mismatches;
        end
    end

endmodule

// ===== tb/sv/tb_generational_handle_table_unit.sv =====
module tb_generational_handle_table_unit;
    import ght_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int IDX_W      = DEF_INDEX_BITS;
    localparam int GEN_W      = HANDLE_W - IDX_W;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [CMD_W-1:0]    i_cmd;
    logic [HANDLE_W-1:0] i_handle;
    logic [SIZE_W-1:0]   i_buf_size;
    logic [USAGE_W-1:0]  i_usage_flags;
    logic [KIND_W-1:0]   i_memory_kind;
    logic [SIZE_W-1:0]   i_write_offset;
    logic [SIZE_W-1:0]   i_write_length;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_handle_out;
    logic [USAGE_W-1:0]  o_usage_out;
    logic [SIZE_W-1:0]   o_size_out;
    logic [KIND_W-1:0]   o_kind_out;
    logic                o_staged_path;

    int fail_count;
    int pending;

    // handles seen on successful creates, used to aim later commands
    logic [HANDLE_W-1:0] live_handles[$];
    int                  burst_left;
    t_stall_mode         stall_mode;
    int                  stall_left;

    generational_handle_table_unit #(
        .SLOT_COUNT(DEF_SLOT_COUNT),
        .INDEX_BITS(DEF_INDEX_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cmd(i_cmd),
        .i_handle(i_handle),
        .i_buf_size(i_buf_size),
        .i_usage_flags(i_usage_flags),
        .i_memory_kind(i_memory_kind),
        .i_write_offset(i_write_offset),
        .i_write_length(i_write_length),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_handle_out(o_handle_out),
        .o_usage_out(o_usage_out),
        .o_size_out(o_size_out),
        .o_kind_out(o_kind_out),
        .o_staged_path(o_staged_path)
    );

    handle_table_checker #(
        .SLOT_COUNT(DEF_SLOT_COUNT),
        .INDEX_BITS(DEF_INDEX_BITS)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(i_valid),
        .i_req_stall(o_stall),
        .i_cmd(i_cmd),
        .i_handle(i_handle),
        .i_buf_size(i_buf_size),
        .i_usage_flags(i_usage_flags),
        .i_memory_kind(i_memory_kind),
        .i_write_offset(i_write_offset),
        .i_write_length(i_write_length),
        .i_rsp_valid(o_valid),
        .i_rsp_stall(i_stall),
        .i_status(o_status),
        .i_handle_out(o_handle_out),
        .i_usage_out(o_usage_out),
        .i_size_out(o_size_out),
        .i_kind_out(o_kind_out),
        .i_staged_path(o_staged_path),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // receiver stalls, switching between a few patterns
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 80);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 1) == 0);
            default:     i_stall <= ((stall_left % 12) < 5);
        endcase
    end

    // collect handles from successful creates
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall && o_status == ST_OK && o_handle_out != '0)
            live_handles.insert(live_handles.size(), o_handle_out);
    end

    function automatic logic [SIZE_W-1:0] rand40();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[SIZE_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] rand_bytes();
        return rand40() >> $urandom_range(0, SIZE_W - 1);
    endfunction

    function automatic logic [HANDLE_W-1:0] mk_handle(input int unsigned gen,
                                                      input int unsigned idx);
        return HANDLE_W'((gen << IDX_W) | idx);
    endfunction

    // one request transfer, with bursts and random gaps in between
    task automatic send_request(
        input logic [CMD_W-1:0]    cmd,
        input logic [HANDLE_W-1:0] h,
        input logic [SIZE_W-1:0]   bytes,
        input logic [USAGE_W-1:0]  usage,
        input logic [KIND_W-1:0]   kind,
        input logic [SIZE_W-1:0]   offset,
        input logic [SIZE_W-1:0]   length
    );
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_handle       <= h;
        i_buf_size     <= bytes;
        i_usage_flags  <= usage;
        i_memory_kind  <= kind;
        i_write_offset <= offset;
        i_write_length <= length;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_create(input logic [SIZE_W-1:0] bytes, input logic [USAGE_W-1:0] usage,
                               input logic [KIND_W-1:0] kind);
        send_request(CMD_CREATE, $urandom, bytes, usage, kind, rand40(), rand40());
    endtask

    task automatic send_access(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] h,
                               input logic [SIZE_W-1:0] offset,
                               input logic [SIZE_W-1:0] length);
        send_request(cmd, h, rand40(), $urandom, 2'($urandom), offset, length);
    endtask

    // stop sending and wait until every result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // random command, mostly aimed at handles that were handed out
    task automatic send_random_op();
        logic [CMD_W-1:0]    cmd;
        logic [HANDLE_W-1:0] h;
        logic [SIZE_W-1:0]   bytes;
        logic [USAGE_W-1:0]  usage;
        logic [KIND_W-1:0]   kind;
        logic [SIZE_W-1:0]   offset;
        logic [SIZE_W-1:0]   length;
        int                  sel;
        int                  pos;
        sel = $urandom_range(0, 99);
        cmd = (sel < 30) ? CMD_CREATE : (sel < 50) ? CMD_DESTROY :
              (sel < 75) ? CMD_QUERY : CMD_UPLOAD;

        pos = -1;
        sel = $urandom_range(0, 99);
        if (sel < 70 && live_handles.size() > 0) begin
            pos = $urandom_range(0, live_handles.size() - 1);
            h   = live_handles[pos];
        end else if (sel < 80 && live_handles.size() > 0) begin
            // stale generation on a real slot
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
            h[HANDLE_W-1:IDX_W] = h[HANDLE_W-1:IDX_W] + GEN_W'($urandom_range(1, 4094));
        end else if (sel < 90) begin
            h = $urandom;
            h[IDX_W-1:0] = IDX_W'($urandom_range(0, 1100));
        end else begin
            h = $urandom;
        end

        bytes = ($urandom_range(0, 19) == 0) ? '0 : rand_bytes();
        usage = ($urandom_range(0, 19) == 0) ? '0 : USAGE_W'($urandom);
        kind  = ($urandom_range(0, 9) == 0) ? KIND_NONE : KIND_W'($urandom_range(0, 2));

        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            offset = rand40();
            length = '0;
        end else if (sel < 5) begin
            offset = SIZE_W'($urandom_range(0, 255));
            length = SIZE_W'($urandom_range(1, 255));
        end else begin
            offset = rand_bytes();
            length = rand_bytes();
        end

        if (cmd == CMD_DESTROY && pos >= 0) live_handles.delete(pos);
        send_request(cmd, h, bytes, usage, kind, offset, length);
    endtask

    initial begin
        logic [HANDLE_W-1:0] h;
        int                  pos;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_cmd          = CMD_CREATE;
        i_handle       = '0;
        i_buf_size     = '0;
        i_usage_flags  = '0;
        i_memory_kind  = KIND_GPU;
        i_write_offset = '0;
        i_write_length = '0;
        burst_left     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every command and the corner cases
        send_create(SIZE_MAX, '1, KIND_GPU);
        send_create(40'd1, 32'd1, KIND_HOST);
        send_create(40'd100, 32'h8000_0000, KIND_READBACK);
        send_create('0, $urandom, KIND_HOST);
        send_create(40'd64, '0, KIND_HOST);
        send_create(40'd64, 32'h10, KIND_NONE);
        send_access(CMD_QUERY, '0, rand40(), rand40());
        send_access(CMD_QUERY, mk_handle(1, 1), rand40(), rand40());
        send_access(CMD_QUERY, mk_handle(2, 1), rand40(), rand40());
        send_access(CMD_QUERY, mk_handle(1, 5), rand40(), rand40());
        send_access(CMD_QUERY, mk_handle(1, DEF_SLOT_COUNT), rand40(), rand40());
        send_access(CMD_QUERY, '1, rand40(), rand40());
        send_access(CMD_UPLOAD, '0, rand40(), '0);
        send_access(CMD_UPLOAD, mk_handle(1, 1), '0, SIZE_MAX);
        send_access(CMD_UPLOAD, mk_handle(1, 1), 40'd1, SIZE_MAX);
        send_access(CMD_UPLOAD, mk_handle(1, 1), SIZE_MAX, SIZE_MAX);
        send_access(CMD_UPLOAD, mk_handle(1, 2), '0, 40'd1);
        send_access(CMD_UPLOAD, mk_handle(1, 2), 40'd1, 40'd1);
        send_access(CMD_UPLOAD, mk_handle(1, 3), 40'd99, 40'd1);
        send_access(CMD_DESTROY, mk_handle(1, 2), rand40(), rand40());
        send_access(CMD_DESTROY, mk_handle(1, 2), rand40(), rand40());
        send_access(CMD_QUERY, mk_handle(1, 2), rand40(), rand40());
        send_create(40'd7, 32'h4, KIND_HOST);
        send_access(CMD_QUERY, mk_handle(2, 2), rand40(), rand40());
        send_access(CMD_UPLOAD, mk_handle(3, 3), '0, 40'd1);

        // random mix
        for (int n = 0; n < 300; n++) send_random_op();

        // fill a large part of the table, then free much of it
        wait_drained();
        for (int n = 0; n < 320; n++)
            send_create(rand_bytes() | 40'd1, USAGE_W'($urandom) | 32'd1,
                        KIND_W'($urandom_range(0, 2)));
        wait_drained();
        for (int n = 0; n < 200 && live_handles.size() > 0; n++) begin
            pos = $urandom_range(0, live_handles.size() - 1);
            h   = live_handles[pos];
            live_handles.delete(pos);
            send_access(CMD_DESTROY, h, rand40(), rand40());
        end

        for (int n = 0; n < 90; n++) send_random_op();

        // cycle one slot through create and destroy so its generation climbs
        wait_drained();
        for (int n = 0; n < 5; n++) begin
            send_create(rand_bytes() | 40'd1, USAGE_W'($urandom) | 32'd1,
                        KIND_W'($urandom_range(0, 2)));
            wait_drained();
            if (live_handles.size() > 0) begin
                h = live_handles[live_handles.size() - 1];
                live_handles.delete(live_handles.size() - 1);
                send_access(CMD_DESTROY, h, rand40(), rand40());
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #(CLK_PERIOD * 1500000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== generational_handle_table_unit.f =====
rtl/ght_pkg.sv
rtl/ght_ram.sv
rtl/ght_ctrl.sv
rtl/ght_dpath.sv
rtl/generational_handle_table_unit.sv
tb/sv/handle_table_checker.sv
tb/sv/tb_generational_handle_table_unit.sv
